@@ design/u8t_pkg.sv @@
`default_nettype none
package u8t_pkg;

  localparam logic [3:0] TxFrameBits = 4'd10;
  localparam logic [3:0] TxStartLeft = 4'd9;
  localparam logic [3:0] RxDataBits  = 4'd8;

  localparam logic [15:0] BitPeriodReset = 16'd1667;

  typedef struct packed {
    logic line;
    logic busy;
  } tx_status_t;

  typedef struct packed {
    logic       ready;
    logic [7:0] data;
    logic       done;
  } rx_status_t;

endpackage
`default_nettype wire

@@ design/u8t_tx.sv @@
`default_nettype none
module u8t_tx (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic [15:0]       bit_period_i,
  input  wire logic              tx_load_i,
  input  wire logic [7:0]        tx_byte_i,
  output u8t_pkg::tx_status_t    status_o
);

  logic [15:0] phase_q, phase_d;
  logic [3:0]  bits_q, bits_d;
  logic [7:0]  shift_q, shift_d;
  logic        level_q, level_d;
  logic [16:0] phase_inc;

  assign phase_inc = {1'b0, phase_q} + 17'd1;

  always_comb begin
    phase_d = phase_q;
    bits_d  = bits_q;
    shift_d = shift_q;
    level_d = level_q;
    if (phase_inc >= {1'b0, bit_period_i}) begin
      phase_d = '0;
      if (bits_q != 4'd0) begin
        bits_d = bits_q - 4'd1;
        if (bits_d == u8t_pkg::TxStartLeft) begin
          level_d = 1'b0;
        end else if (bits_d == 4'd0) begin
          level_d = 1'b1;
        end else begin
          level_d = shift_q[0];
          shift_d = {1'b0, shift_q[7:1]};
        end
      end
    end else begin
      phase_d = phase_inc[15:0];
    end
    if (tx_load_i && (bits_d == 4'd0)) begin
      shift_d = tx_byte_i;
      bits_d  = u8t_pkg::TxFrameBits;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      bits_q  <= '0;
      shift_q <= '0;
      level_q <= 1'b1;
    end else if (step_i) begin
      phase_q <= phase_d;
      bits_q  <= bits_d;
      shift_q <= shift_d;
      level_q <= level_d;
    end
  end

  assign status_o.line = level_q;
  assign status_o.busy = (bits_q != 4'd0);

  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && tx_load_i && (bits_q == 4'd0) |=> bits_q == u8t_pkg::TxFrameBits)
    else $error("load on idle transmitter did not start a frame");

  a_idle_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bits_q == 4'd0) |-> level_q)
    else $error("idle transmitter not driving high");

  a_bits_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_q <= u8t_pkg::TxFrameBits)
    else $error("transmit bit count out of range");

endmodule
`default_nettype wire

@@ design/u8t_rx.sv @@
`default_nettype none
module u8t_rx (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic [15:0]       bit_period_i,
  input  wire logic              rx_line_i,
  input  wire logic              rx_ack_i,
  output u8t_pkg::rx_status_t    status_o
);

  logic        active_q, active_d;
  logic [16:0] timer_q, timer_d;
  logic [3:0]  idx_q, idx_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  held_q, held_d;
  logic        full_q, full_d;
  logic        prev_q;
  logic        done_q, done_d;
  logic [17:0] period_x3;

  assign period_x3 = {1'b0, bit_period_i, 1'b0} + {2'b00, bit_period_i};

  always_comb begin
    active_d = active_q;
    timer_d  = timer_q;
    idx_d    = idx_q;
    shift_d  = shift_q;
    held_d   = held_q;
    full_d   = rx_ack_i ? 1'b0 : full_q;
    done_d   = 1'b0;
    if (active_q) begin
      if (timer_q <= 17'd1) begin
        if (idx_q < u8t_pkg::RxDataBits) begin
          shift_d = shift_q | (8'(rx_line_i) << idx_q[2:0]);
          idx_d   = idx_q + 4'd1;
          timer_d = {1'b0, bit_period_i};
        end else begin
          held_d   = shift_q;
          full_d   = 1'b1;
          done_d   = 1'b1;
          active_d = 1'b0;
          timer_d  = '0;
          idx_d    = '0;
        end
      end else begin
        timer_d = timer_q - 17'd1;
      end
    end else if (prev_q && !rx_line_i) begin
      active_d = 1'b1;
      timer_d  = period_x3[17:1];
      idx_d    = '0;
      shift_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      timer_q  <= '0;
      idx_q    <= '0;
      shift_q  <= '0;
      held_q   <= '0;
      full_q   <= 1'b0;
      prev_q   <= 1'b1;
      done_q   <= 1'b0;
    end else if (step_i) begin
      active_q <= active_d;
      timer_q  <= timer_d;
      idx_q    <= idx_d;
      shift_q  <= shift_d;
      held_q   <= held_d;
      full_q   <= full_d;
      prev_q   <= rx_line_i;
      done_q   <= done_d;
    end
  end

  assign status_o.ready = full_q;
  assign status_o.data  = held_q;
  assign status_o.done  = done_q;

  a_done_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> full_q)
    else $error("completed byte not flagged ready");

  a_idle_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (idx_q == 4'd0))
    else $error("bit index nonzero while hunting for start");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= u8t_pkg::RxDataBits)
    else $error("receive bit index out of range");

endmodule
`default_nettype wire

@@ design/uart_8n1_transceiver.sv @@
// latency: the result of an item is presented on the cycle after it is accepted
// throughput: one item per cycle while out_ready_i takes results; the result register frees as its item is taken
// the state registers double as the result register and update only on accept
// reset is asynchronous active low: tx line idles high, receiver hunts for start
// bit period returns to 1667 accepted items per bit on reset
`default_nettype none
module uart_8n1_transceiver (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        rx_line_i,
  input  wire logic        tx_load_i,
  input  wire logic [7:0]  tx_byte_i,
  input  wire logic        rx_ack_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             tx_line_o,
  output logic             tx_busy_o,
  output logic             rx_ready_o,
  output logic [7:0]       rx_byte_o,
  output logic             rx_done_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic        step;
  logic        out_valid_q;
  logic [15:0] bit_period_q;
  u8t_pkg::tx_status_t tx_status;
  u8t_pkg::rx_status_t rx_status;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign step       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_period_q <= u8t_pkg::BitPeriodReset;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      bit_period_q <= pwdata[15:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {16'd0, bit_period_q};

  u8t_tx u_tx (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .bit_period_i (bit_period_q),
    .tx_load_i    (tx_load_i),
    .tx_byte_i    (tx_byte_i),
    .status_o     (tx_status)
  );

  u8t_rx u_rx (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .bit_period_i (bit_period_q),
    .rx_line_i    (rx_line_i),
    .rx_ack_i     (rx_ack_i),
    .status_o     (rx_status)
  );

  assign out_valid_o = out_valid_q;
  assign tx_line_o   = tx_status.line;
  assign tx_busy_o   = tx_status.busy;
  assign rx_ready_o  = rx_status.ready;
  assign rx_byte_o   = rx_status.data;
  assign rx_done_o   = rx_status.done;

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_q && !out_ready_i)
    else $error("input stalled without a waiting result");

  a_result_after_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("accepted item produced no result");

  a_status_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |=> $stable(rx_status) && $stable(tx_status))
    else $error("status changed without an accepted item");

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] BitPeriodAddr = 3'd0;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseCount = 8;

  typedef struct packed {
    u8t_pkg::tx_status_t tx;
    u8t_pkg::rx_status_t rx;
  } line_status_t;

  typedef enum logic [1:0] {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;

  class uart_status_tracker;
    logic [15:0] period;
    logic [15:0] tx_phase;
    logic [3:0]  tx_left;
    logic [7:0]  tx_bits;
    logic        tx_level;
    logic        rx_busy;
    logic [16:0] rx_count;
    logic [3:0]  rx_index;
    logic [7:0]  rx_bits;
    logic [7:0]  rx_hold;
    logic        rx_full;
    logic        rx_last;
    line_status_t status_due[$];
    int unsigned mismatches;

    function new();
      period     = u8t_pkg::BitPeriodReset;
      tx_phase   = '0;
      tx_left    = '0;
      tx_bits    = '0;
      tx_level   = 1'b1;
      rx_busy    = 1'b0;
      rx_count   = '0;
      rx_index   = '0;
      rx_bits    = '0;
      rx_hold    = '0;
      rx_full    = 1'b0;
      rx_last    = 1'b1;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return status_due.size();
    endfunction

    // one accepted step of the uart: transmitter first, then receiver
    function void note_tick(logic line, logic load, logic [7:0] data, logic ack);
      line_status_t want;
      logic [17:0]  span;
      logic         done;
      done = 1'b0;
      if ({1'b0, tx_phase} + 17'd1 >= {1'b0, period}) begin
        tx_phase = '0;
        if (tx_left != 4'd0) begin
          tx_left = tx_left - 4'd1;
          if (tx_left == u8t_pkg::TxStartLeft) begin
            tx_level = 1'b0;
          end else if (tx_left == 4'd0) begin
            tx_level = 1'b1;
          end else begin
            tx_level = tx_bits[0];
            tx_bits  = tx_bits >> 1;
          end
        end
      end else begin
        tx_phase = tx_phase + 16'd1;
      end
      if (load && tx_left == 4'd0) begin
        tx_bits = data;
        tx_left = u8t_pkg::TxFrameBits;
      end

      if (ack) rx_full = 1'b0;
      if (rx_busy) begin
        if (rx_count <= 17'd1) begin
          if (rx_index < u8t_pkg::RxDataBits) begin
            rx_bits  = rx_bits | (8'(line) << rx_index[2:0]);
            rx_index = rx_index + 4'd1;
            rx_count = {1'b0, period};
          end else begin
            rx_hold  = rx_bits;
            rx_full  = 1'b1;
            done     = 1'b1;
            rx_busy  = 1'b0;
            rx_count = '0;
            rx_index = '0;
          end
        end else begin
          rx_count = rx_count - 17'd1;
        end
      end else if (rx_last && !line) begin
        // first sample one and a half bits after the start edge
        span     = {2'b00, period} * 18'd3;
        rx_busy  = 1'b1;
        rx_count = span[17:1];
        rx_index = '0;
        rx_bits  = '0;
      end
      rx_last = line;

      want.tx.line  = tx_level;
      want.tx.busy  = (tx_left != 4'd0);
      want.rx.ready = rx_full;
      want.rx.data  = rx_hold;
      want.rx.done  = done;
      status_due.push_back(want);
    endfunction

    function void check_field(string what, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t %s: expected %0h, got %0h", $time, what, want, got);
      end
    endfunction

    function void check_status(line_status_t got);
      line_status_t want;
      if (status_due.size() == 0) begin
        mismatches++;
        $display("%0t status with no item pending: expected none, got %0h", $time, got);
      end else begin
        want = status_due.pop_front();
        check_field("tx_line", 8'(want.tx.line), 8'(got.tx.line));
        check_field("tx_busy", 8'(want.tx.busy), 8'(got.tx.busy));
        check_field("rx_ready", 8'(want.rx.ready), 8'(got.rx.ready));
        check_field("rx_byte", want.rx.data, got.rx.data);
        check_field("rx_done", 8'(want.rx.done), 8'(got.rx.done));
      end
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic        rx_line_i   = 1'b1;
  logic        tx_load_i   = 1'b0;
  logic [7:0]  tx_byte_i   = 8'h00;
  logic        rx_ack_i    = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        tx_line_o;
  logic        tx_busy_o;
  logic        rx_ready_o;
  logic [7:0]  rx_byte_o;
  logic        rx_done_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = 3'd0;
  logic [31:0] pwdata      = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  uart_status_tracker tracker = new();
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  logic rx_wave[$];
  int unsigned phase_period [PhaseCount] = '{65535, 4, 5, 4, 6, 4, 7, 5};
  int unsigned phase_items [PhaseCount] = '{40, 150, 150, 150, 150, 150, 150, 150};

  uart_8n1_transceiver u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_line_i  (rx_line_i),
    .tx_load_i  (tx_load_i),
    .tx_byte_i  (tx_byte_i),
    .rx_ack_i   (rx_ack_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .tx_line_o  (tx_line_o),
    .tx_busy_o  (tx_busy_o),
    .rx_ready_o (rx_ready_o),
    .rx_byte_o  (rx_byte_o),
    .rx_done_o  (rx_done_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        tracker.note_tick(rx_line_i, tx_load_i, tx_byte_i, rx_ack_i);
      end
      if (out_valid_o && out_ready_i) begin
        tracker.check_status(line_status_t'({tx_line_o, tx_busy_o, rx_ready_o,
                                             rx_byte_o, rx_done_o}));
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic void set_idling(idle_mode_e mode);
    case (mode)
      IdleNone: begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      IdleSender: begin
        send_idle_pct = 48;
        stall_pct     = 0;
      end
      IdleReceiver: begin
        send_idle_pct = 0;
        stall_pct     = 48;
      end
      default: begin
        send_idle_pct = 8;
        stall_pct     = 8;
      end
    endcase
  endfunction

  // idle gap, then a frame with random or uniform content (stop bit sometimes short or low), or a short low glitch
  function automatic void plan_rx_frame();
    int unsigned bit_len;
    int unsigned gap;
    int unsigned kind;
    int unsigned stop_len;
    int unsigned i;
    logic [7:0]  data;
    logic        stop_level;
    bit_len    = (tracker.period > 64) ? 64 : tracker.period;
    kind       = $urandom_range(99);
    gap        = $urandom_range(bit_len / 2);
    data       = (kind < 20) ? {8{kind[0]}} : 8'($urandom_range(255));
    stop_len   = (kind < 40) ? $urandom_range(bit_len, 1) : bit_len;
    stop_level = !(kind >= 80 && kind < 85);
    repeat (gap) rx_wave.push_back(1'b1);
    if (kind >= 90) begin
      repeat ($urandom_range(bit_len, 1)) rx_wave.push_back(1'b0);
    end else begin
      repeat (bit_len) rx_wave.push_back(1'b0);
      for (i = 0; i < 8; i++) begin
        repeat (bit_len) rx_wave.push_back(data[i]);
      end
      repeat (stop_len) rx_wave.push_back(stop_level);
    end
  endfunction

  function automatic logic next_rx_level();
    if (rx_wave.size() == 0) plan_rx_frame();
    return rx_wave.pop_front();
  endfunction

  task automatic drive_tick(logic line, logic load, logic [7:0] data, logic ack);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_line_i  <= line;
    tx_load_i  <= load;
    tx_byte_i  <= data;
    rx_ack_i   <= ack;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.pending() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_bit_period(logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= BitPeriodAddr;
    pwdata  <= {16'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.period = value;
    // read back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {16'd0, value}) begin
      tracker.mismatches++;
      $display("%0t bit_period readback: expected %0h, got %0h", $time, value, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    int unsigned p;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset bit period, field extremes, load while busy, edges while receiving
    drive_tick(1'b1, 1'b0, 8'h00, 1'b0);
    drive_tick(1'b1, 1'b1, 8'hFF, 1'b0);
    drive_tick(1'b1, 1'b1, 8'h00, 1'b1);
    drive_tick(1'b0, 1'b0, 8'hFF, 1'b0);
    drive_tick(1'b1, 1'b0, 8'h00, 1'b1);
    drive_tick(1'b0, 1'b1, 8'hAA, 1'b0);
    drive_tick(1'b0, 1'b0, 8'h55, 1'b1);
    drive_tick(1'b1, 1'b1, 8'hFF, 1'b1);
    drive_tick(1'b1, 1'b0, 8'h00, 1'b0);
    drain_results();

    // longest period first, then short ones so the phase count lands past the period
    for (p = 0; p < PhaseCount; p++) begin
      set_idling(idle_mode_e'(p % 4));
      set_bit_period(16'(phase_period[p]));
      rx_wave.delete();
      repeat (phase_items[p]) begin
        drive_tick(next_rx_level(), $urandom_range(99) < 8, 8'($urandom_range(255)),
                   $urandom_range(99) < 15);
      end
      drain_results();
    end

    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
